[rtl/ierr_pkg.sv]
// Package: shared types and constants of the input event range remapper.
`default_nettype none
package ierr_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    KIND_EVENT = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_CLEAR,
    ST_FULL
  } state_e;

  // One table entry.
  typedef struct packed {
    logic [15:0] rtype;
    logic [15:0] rcode;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] tgt;
    logic [31:0] seen;
    logic        act;
  } rule_t;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic        shift;   // every cell above pos takes its lower neighbor
    logic        ins;     // cell at pos takes the new rule
    logic [IdxW-1:0] pos;
    logic        upd;     // cell at pos takes upd_rule
    logic        clr;
  } cell_ctl_t;

  function automatic logic [31:0] seen_init(logic [31:0] lo, logic [31:0] hi);
    seen_init = (lo == 32'h8000_0000) ? hi + 32'd1 : lo - 32'd1;
  endfunction
endpackage
`default_nettype wire

[rtl/ierr_cell.sv]
// One table cell: holds one rule, shifts up from its lower neighbor on insert.
`default_nettype none
module ierr_cell (
  input  wire logic                   clk_i,
  input  wire logic [ierr_pkg::IdxW-1:0] idx_i,
  input  wire ierr_pkg::cell_ctl_t    ctl_i,
  input  wire ierr_pkg::rule_t        lower_i,
  input  wire ierr_pkg::rule_t        new_i,
  output ierr_pkg::rule_t             rule_o
);
  import ierr_pkg::*;
  rule_t rule_q;

  // Entry register; table contents are undefined until written.
  always_ff @(posedge clk_i) begin
    if ((ctl_i.ins || ctl_i.upd) && idx_i == ctl_i.pos) begin
      rule_q <= new_i;
    end else if (ctl_i.shift && idx_i > ctl_i.pos) begin
      rule_q <= lower_i;
    end
  end
  assign rule_o = rule_q;
endmodule
`default_nettype wire

[rtl/input_event_range_remapper_unit.sv]
// Top level: sequencer, chain of rule cells and output register.
// One item is in work at a time; in_stall_o stays high from the accepting edge until the
// item's walk is over and its last result has left the pending register. A none item
// and an event of type 0 or 4 are dropped and do not raise it. An accepted event walks
// the rule cells one per cycle from index 0 while the output lets it. An add walks the
// cells to find its slot, then every cell above the slot takes its lower neighbor; an
// add that finds the table full gives a single table-full result. A clear releases one
// held bit per cycle while the output lets it, 32 bits at most, and a clear with nothing
// held gives no result. Results pass through a pending register and the output register,
// one per cycle while the receiver takes them; receiver stall holds the walk once both
// are full. A result stays pending until the walk shows whether it is the item's last.
`default_nettype none
module input_event_range_remapper_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [15:0] ev_type_i,
  input  wire logic [15:0] ev_code_i,
  input  wire logic [31:0] ev_value_i,
  input  wire logic [31:0] rule_lo_i,
  input  wire logic [31:0] rule_hi_i,
  input  wire logic [31:0] rule_target_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      button_mask_o,
  output logic             pressed_o,
  output logic             table_full_o,
  output logic [31:0]      held_after_o,
  output logic             last_o
);
  import ierr_pkg::*;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [31:0] held_q, held_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [15:0] type_q, code_q;
  logic [31:0] val_q, lo_q, hi_q, tgt_q;
  logic pend_q, pend_d;
  logic [31:0] pmask_q, pmask_d, pheld_q, pheld_d;
  logic ppress_q, ppress_d, pfull_q, pfull_d;
  logic plast_q, plast_d;
  logic ov_q, ov_d;
  logic [31:0] obm_q, oheld_q;
  logic opr_q, ofull_q, olast_q;
  rule_t cur_q;

  rule_t cells [TableDepth];
  rule_t new_rule, upd_rule, cur;
  cell_ctl_t ctl;
  logic accept, out_take, emit, done_item, load_p, move_p;
  logic [31:0] key_in, key_cur;
  logic in_rng, act_new;
  logic [4:0] hb;

  // Chain of cells; each cell sees its lower neighbor.
  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    rule_t lower;
    if (g == 0) begin : g_first
      assign lower = new_rule;
    end else begin : g_rest
      assign lower = cells[g-1];
    end
    ierr_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (IdxW'(g)),
      .ctl_i  (ctl),
      .lower_i(lower),
      .new_i  (ctl.upd ? upd_rule : new_rule),
      .rule_o (cells[g])
    );
  end

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || pend_q;
  assign out_take = ov_q && !out_stall_i;

  // entry under the walk pointer, read into a register
  assign cur = cur_q;
  assign key_in = {type_q, code_q};
  assign key_cur = {cur.rtype, cur.rcode};
  assign in_rng = ($signed(val_q) >= $signed(cur.lo)) && ($signed(val_q) <= $signed(cur.hi));

  always_comb begin
    new_rule.rtype = type_q;
    new_rule.rcode = code_q;
    new_rule.lo = lo_q;
    new_rule.hi = hi_q;
    new_rule.tgt = tgt_q;
    new_rule.seen = seen_init(lo_q, hi_q);
    new_rule.act = 1'b0;
    upd_rule = cur;
    upd_rule.seen = val_q;
    upd_rule.act = in_rng;
  end

  // highest held bit
  always_comb begin
    hb = '0;
    for (int b = 0; b < 32; b++) begin
      if (held_q[b]) hb = 5'(b);
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    held_d = held_q;
    ptr_d = ptr_q;
    load_p = 1'b0;
    pmask_d = pmask_q;
    pheld_d = pheld_q;
    ppress_d = ppress_q;
    pfull_d = pfull_q;
    ctl = '0;
    ctl.pos = ptr_q[IdxW-1:0];
    emit = 1'b0;
    done_item = 1'b0;
    act_new = in_rng;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ptr_d = '0;
          case (kind_i)
            KIND_EVENT: begin
              if (ev_type_i != 16'd0 && ev_type_i != 16'd4) state_d = ST_SCAN;
            end
            KIND_ADD: state_d = (count_q == CntW'(TableDepth)) ? ST_FULL : ST_INSERT;
            KIND_CLEAR: state_d = ST_CLEAR;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_FULL: begin
        if (!pend_q || !ov_q) begin
          load_p = 1'b1; pmask_d = '0; ppress_d = 1'b0; pfull_d = 1'b1;
          pheld_d = held_q; state_d = ST_IDLE;
        end
      end
      ST_INSERT: begin
        if (ptr_q < count_q && key_cur < key_in) begin
          ptr_d = ptr_q + 1'b1;
        end else begin
          ctl.shift = 1'b1;
          ctl.ins = 1'b1;
          count_d = count_q + 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (pend_q && ov_q && !out_take) begin
          // wait for room
        end else if (ptr_q < count_q && key_cur < key_in) begin
          ptr_d = ptr_q + 1'b1;
        end else if (ptr_q < count_q && key_cur == key_in) begin
          ptr_d = ptr_q + 1'b1;
          if (val_q != cur.seen) begin
            ctl.upd = 1'b1;
            if (act_new != cur.act) begin
              if (act_new && (held_q & cur.tgt) == '0) begin
                held_d = held_q | cur.tgt;
                emit = 1'b1;
              end else if (!act_new && (held_q & cur.tgt) != '0) begin
                held_d = held_q & ~cur.tgt;
                emit = 1'b1;
              end
            end
          end
          if (emit) begin
            load_p = 1'b1; pmask_d = cur.tgt; ppress_d = act_new; pfull_d = 1'b0;
            pheld_d = held_d;
          end
        end else begin
          done_item = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (pend_q && ov_q && !out_take) begin
          // wait
        end else if (held_q != '0) begin
          held_d = held_q & ~(32'd1 << hb);
          load_p = 1'b1; pmask_d = 32'd1 << hb; ppress_d = 1'b0; pfull_d = 1'b0;
          pheld_d = held_d;
          if (held_d == '0) begin
            count_d = '0;
            state_d = ST_IDLE;
          end
        end else begin
          count_d = '0;
          done_item = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // last marking: known at once for full and clear results
  always_comb begin
    plast_d = 1'b0;
    if (state_q == ST_FULL) plast_d = 1'b1;
    if (state_q == ST_CLEAR && held_q != '0 && held_d == '0) plast_d = 1'b1;
  end

  // Pending result moves on once the output is free and its last flag is settled:
  // a newer result follows it, or the item's walk is over.
  assign move_p = pend_q && (!ov_q || out_take) &&
                  (plast_q || load_p || done_item || state_q == ST_IDLE);
  assign pend_d = load_p || (pend_q && !move_p);
  assign ov_d = move_p || (ov_q && !out_take);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      held_q <= '0;
      ptr_q <= '0;
      pend_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      held_q <= held_d;
      ptr_q <= ptr_d;
      pend_q <= pend_d;
      ov_q <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cells[ptr_d[IdxW-1:0]];
    if (accept) begin
      type_q <= ev_type_i;
      code_q <= ev_code_i;
      val_q <= ev_value_i;
      lo_q <= rule_lo_i;
      hi_q <= rule_hi_i;
      tgt_q <= rule_target_i;
    end
    if (move_p) begin
      obm_q <= pmask_q;
      opr_q <= ppress_q;
      ofull_q <= pfull_q;
      oheld_q <= pheld_q;
      olast_q <= plast_q || !load_p;
    end
    if (load_p) begin
      pmask_q <= pmask_d;
      ppress_q <= ppress_d;
      pfull_q <= pfull_d;
      pheld_q <= pheld_d;
      plast_q <= plast_d;
    end
  end

  assign out_valid_o = ov_q;
  assign button_mask_o = obm_q;
  assign pressed_o = opr_q;
  assign table_full_o = ofull_q;
  assign held_after_o = oheld_q;
  assign last_o = olast_q;

  // Assertions
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth)) else $error("rule count overflow");
  a_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("accept while busy");
  a_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && table_full_o) |-> (button_mask_o == '0 && last_o))
    else $error("bad full result");
  a_clear_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && held_q == '0) |=> count_q == '0)
    else $error("table not cleared");
endmodule
`default_nettype wire
